// File: src/swr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the sample-without-replacement block
// no dependencies

package swr_pkg;

	localparam int CFG_W   = 13;
	localparam int IDX_W   = 12;
	localparam int VAL_W   = 12;
	localparam int STAT_W  = 2;
	localparam int EPOCH_W = 8;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_POPULATION_SIZE = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT    = 1'd1;

	localparam logic [CFG_W-1:0] POPULATION_RESET = 13'd4096;
	localparam logic [CFG_W-1:0] SAMPLE_RESET     = 13'd4096;

	localparam logic MODE_RESTART = 1'b0;
	localparam logic MODE_DRAW    = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EXHAUSTED = 2'd1,
		STAT_RANGE     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

`default_nettype wire

// File: src/swr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// generic ram: one write port, two read ports with registered read data
// no dependencies

module swr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr_a,
	input  wire  [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// File: src/sample_without_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// Draws distinct values 0..population_size-1 by a partial Fisher-Yates shuffle.
// The accept cycle issues both reads of the remap ram (drawn slot and last live
// slot); the next cycle sees the registered read data and, once the result
// register is free, writes the last live value back into the drawn slot on a
// good draw and loads the result register. One item is in work at a time: a
// new item is taken only after the result register is loaded. Ram entries carry
// an epoch tag; a restart bumps the epoch instead of clearing the table. After
// reset, and after every 255th restart, a clearing pass over all MAX_POPULATION
// entries rewrites the tags while no item is accepted (config writes still land).
// depends on swr_pkg and swr_ram

module sample_without_replacement #(
	parameter int MAX_POPULATION = 4096
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [swr_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire  [swr_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [15:0]                   s_tdata,  // draw_index[11:0], zero pad
	input  wire                           s_tuser,  // mode
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [15:0]                   m_tdata   // picked_value[11:0], status[13:12], zero pad
);

	import swr_pkg::*;

	localparam int AW = $clog2(MAX_POPULATION);
	localparam int MW = AW + EPOCH_W;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_POPULATION - 1);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]   population_q, sample_q, draws_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      clr_q;

	logic               restart_s1, wrap_s1;
	status_t            status_s1;
	logic [AW-1:0]      idx_s1, last_s1;

	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	logic [IDX_W-1:0]   draw_index;
	logic [CFG_W-1:0]   n_eff, q_eff, live, last_full;
	logic               exhausted, out_of_range;
	status_t            status_d;
	logic               accept, out_free;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr;
	logic [MW-1:0]      ram_wdata, rdata_a, rdata_b;
	logic [AW-1:0]      val_a, val_b;
	logic               exec_done, write_back;
	logic [VAL_W-1:0]   picked;

	assign draw_index = s_tdata[IDX_W-1:0];
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;

	// effective population, sample count and live range
	always_comb begin
		n_eff = (32'(population_q) > MAX_POPULATION) ? CFG_W'(MAX_POPULATION) : population_q;
		q_eff = (sample_q > n_eff) ? n_eff : sample_q;
		exhausted    = draws_q >= q_eff;
		live         = n_eff - draws_q;
		last_full    = live - CFG_W'(1);
		out_of_range = {1'b0, draw_index} >= live;
		if (exhausted) begin
			status_d = STAT_EXHAUSTED;
		end else if (out_of_range) begin
			status_d = STAT_RANGE;
		end else begin
			status_d = STAT_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = (restart_s1 && wrap_s1) ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready  = 1'b0;
		exec_done = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_EXEC: begin
				exec_done = out_free;
				ram_we    = out_free && write_back;
				ram_waddr = idx_s1;
				ram_wdata = {epoch_q, val_b};
			end
			default: ;
		endcase
	end

	assign ram_re = accept;

	swr_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_POPULATION)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (AW'(draw_index)),
		.raddr_b (last_full[AW-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// entries tagged with another epoch read as identity
	assign val_a = (rdata_a[MW-1:AW] == epoch_q) ? rdata_a[AW-1:0] : idx_s1;
	assign val_b = (rdata_b[MW-1:AW] == epoch_q) ? rdata_b[AW-1:0] : last_s1;
	assign write_back = !restart_s1 && (status_s1 == STAT_OK);
	assign picked = write_back ? VAL_W'(val_a) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			population_q <= POPULATION_RESET;
			sample_q     <= SAMPLE_RESET;
			draws_q      <= '0;
			epoch_q      <= EPOCH_FIRST;
			clr_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_POPULATION_SIZE: population_q <= cfg_wdata;
					REG_SAMPLE_COUNT:    sample_q     <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == CLR_LAST) ? '0 : clr_q + AW'(1);
			end
			if (accept && s_tuser == MODE_RESTART) begin
				draws_q <= '0;
				epoch_q <= (epoch_q == EPOCH_MAX) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
			end else if (exec_done && write_back) begin
				draws_q <= draws_q + CFG_W'(1);
			end
			if (exec_done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_s1 <= (s_tuser == MODE_RESTART);
			wrap_s1    <= (epoch_q == EPOCH_MAX);
			status_s1  <= status_d;
			idx_s1     <= AW'(draw_index);
			last_s1    <= last_full[AW-1:0];
		end
		if (exec_done) begin
			m_tdata_q <= {2'b00, (restart_s1 ? STAT_OK : status_s1), picked};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// File: src/swr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// port-level checks for sample_without_replacement, bound to the top level
// depends on swr_pkg

module swr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);

	import swr_pkg::*;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// status code is always a defined one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:12] == STAT_OK || m_tdata[13:12] == STAT_EXHAUSTED ||
			m_tdata[13:12] == STAT_RANGE))
		else $error("undefined status code");

	// a failed draw returns zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13:12] != STAT_OK |-> m_tdata[11:0] == '0)
		else $error("failed draw with nonzero value");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

endmodule

bind sample_without_replacement swr_checker u_swr_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for sample_without_replacement: stream driver, result monitor,
// own shuffle predictor and a phase sequencer that rewrites the two registers
// depends on swr_pkg and the sample_without_replacement rtl

module testbench;
	import swr_pkg::*;

	localparam int MAX_POP    = 4096;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		logic             mode;
		logic [IDX_W-1:0] index;
	} draw_req_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		status_t          status;
	} pick_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;   // draw_index[11:0], zero pad
	logic                 s_tuser = 1'b0; // mode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;        // picked_value[11:0], status[13:12], zero pad

	draw_req_t feed_q[$];
	pick_t     pick_q[$];
	int        error_count = 0;
	int        idle_cycles = 0;
	bit        in_taken = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        gap_max = 3;
	int        stall_pct = 20;
	int        hold_left = 0;
	int        hold_asked = 0;
	int        hold_served = 0;

	// predictor state
	logic [CFG_W-1:0] cfg_population = POPULATION_RESET;
	logic [CFG_W-1:0] cfg_quota = SAMPLE_RESET;
	logic [VAL_W-1:0] shuffle_table [MAX_POP];
	bit               shuffle_set [MAX_POP];
	int unsigned      draw_count = 0;

	sample_without_replacement #(.MAX_POPULATION(MAX_POP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [VAL_W-1:0] slot_value(int unsigned slot);
		return shuffle_set[slot] ? shuffle_table[slot] : slot[VAL_W-1:0];
	endfunction

	function automatic pick_t compute_pick(logic mode, logic [IDX_W-1:0] index);
		pick_t       r;
		int unsigned n, q, live;
		r.value = '0;
		r.status = STAT_OK;
		if (mode == MODE_RESTART) begin
			foreach (shuffle_set[i]) shuffle_set[i] = 1'b0;
			draw_count = 0;
			return r;
		end
		n = (cfg_population > MAX_POP) ? MAX_POP : cfg_population;
		q = (cfg_quota > n) ? n : cfg_quota;
		if (draw_count >= q) begin
			r.status = STAT_EXHAUSTED;
			return r;
		end
		live = n - draw_count;
		if (index >= live) begin
			r.status = STAT_RANGE;
			return r;
		end
		r.value = slot_value(32'(index));
		shuffle_table[index] = slot_value(live - 1);
		shuffle_set[index] = 1'b1;
		draw_count++;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		$display("%0t mismatch on %s: got %h expected %h", $realtime, field, got, want);
		error_count++;
	endtask

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin : drive
		draw_req_t it;
		logic      next_valid;
		if (arst_n && (!s_tvalid || in_taken)) begin
			next_valid = 1'b0;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (feed_q.size() > 0) begin
				it = feed_q.pop_front();
				next_valid = 1'b1;
				burst_left--;
				s_tuser <= it.mode;
				s_tdata <= {4'b0, it.index};
			end
			s_tvalid <= next_valid;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : observe
		pick_t want;
		bit    out_taken;
		in_taken = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (out_taken) begin
			if (pick_q.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata, '0);
			end else begin
				want = pick_q.pop_front();
				if (m_tdata[11:0] !== want.value)
					report_mismatch("picked_value", 16'(m_tdata[11:0]), 16'(want.value));
				if (m_tdata[13:12] !== want.status)
					report_mismatch("status", 16'(m_tdata[13:12]), 16'(want.status));
				if (m_tdata[15:14] !== 2'b00)
					report_mismatch("pad", 16'(m_tdata[15:14]), '0);
			end
		end
		if (in_taken)
			pick_q.push_back(compute_pick(s_tuser, s_tdata[IDX_W-1:0]));
		idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic queue_draw(logic mode, logic [IDX_W-1:0] index);
		draw_req_t it;
		it.mode = mode;
		it.index = index;
		feed_q.push_back(it);
	endtask

	task automatic drain();
		while (feed_q.size() != 0 || s_tvalid || pick_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
	endtask

	task automatic set_regs(logic [CFG_W-1:0] population, logic [CFG_W-1:0] quota);
		drain();
		repeat (4) @(posedge clk);
		write_reg(REG_POPULATION_SIZE, population);
		write_reg(REG_SAMPLE_COUNT, quota);
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_population = population;
		cfg_quota = quota;
	endtask

	// mostly legal draws below the live count, some restarts, boundary and noise indexes
	task automatic fill_random(int count);
		int unsigned      n, q, done, live;
		int               r;
		logic             mode;
		logic [IDX_W-1:0] index;
		n = (cfg_population > MAX_POP) ? MAX_POP : cfg_population;
		q = (cfg_quota > n) ? n : cfg_quota;
		done = draw_count;
		repeat (count) begin
			r = $urandom_range(0, 99);
			live = (done >= n) ? 0 : n - done;
			mode = MODE_DRAW;
			index = IDX_W'($urandom);
			if (r < 6 || (done >= q && r < 40))
				mode = MODE_RESTART;
			else if (r < 88 && live > 0 && done < q)
				index = IDX_W'($urandom_range(0, live - 1));
			else if (r < 94 && live < MAX_POP)
				index = IDX_W'(live);
			queue_draw(mode, index);
			if (mode == MODE_RESTART)
				done = 0;
			else if (done < q && index < live)
				done++;
		end
	endtask

	initial begin : sequencer
		int unsigned pop, quota;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// full population: top index, out of range, slot reuse, alternating bits
		queue_draw(MODE_DRAW, 12'hFFF);
		queue_draw(MODE_DRAW, 12'hFFF);
		queue_draw(MODE_DRAW, 12'h000);
		queue_draw(MODE_DRAW, 12'h000);
		queue_draw(MODE_DRAW, 12'hAAA);
		queue_draw(MODE_DRAW, 12'h555);
		queue_draw(MODE_RESTART, 12'hFFF);
		queue_draw(MODE_DRAW, 12'hFFF);
		// single value: exhausted, then range, a good draw and exhausted after restart
		set_regs(13'd1, 13'd1);
		queue_draw(MODE_DRAW, 12'h000);
		queue_draw(MODE_RESTART, 12'h000);
		queue_draw(MODE_DRAW, 12'h001);
		queue_draw(MODE_DRAW, 12'h000);
		queue_draw(MODE_DRAW, 12'h000);
		// zero population
		set_regs(13'd0, 13'd5);
		queue_draw(MODE_DRAW, 12'h000);
		// exhaustion takes precedence over range
		set_regs(13'd3, 13'd2);
		queue_draw(MODE_RESTART, 12'h000);
		queue_draw(MODE_DRAW, 12'h002);
		queue_draw(MODE_DRAW, 12'h000);
		queue_draw(MODE_DRAW, 12'hFFF);
		// oversized registers saturate, then a zero sample count exhausts at once
		set_regs(13'h1FFF, 13'h1FFF);
		queue_draw(MODE_RESTART, 12'h000);
		queue_draw(MODE_DRAW, 12'hFFF);
		set_regs(13'd10, 13'd0);
		queue_draw(MODE_DRAW, 12'h000);
		// population lowered to the draw count mid-run, then raised again
		set_regs(13'd10, 13'd10);
		queue_draw(MODE_DRAW, 12'h000);
		queue_draw(MODE_DRAW, 12'h001);
		queue_draw(MODE_DRAW, 12'h002);
		set_regs(13'd4, 13'd10);
		queue_draw(MODE_DRAW, 12'h000);
		set_regs(13'd6, 13'd10);
		queue_draw(MODE_DRAW, 12'h001);

		for (int k = 0; k < 10; k++) begin
			if (k == 5) begin
				// restart storm: stale entries must never show after a restart
				set_regs(13'd2, 13'd2);
				repeat (260) begin
					queue_draw(MODE_RESTART, IDX_W'($urandom));
					queue_draw(MODE_DRAW, 12'h000);
					if ($urandom_range(0, 1))
						queue_draw(MODE_DRAW, 12'h000);
				end
			end
			case (k)
				0: begin pop = MAX_POP; quota = MAX_POP; end
				1: begin pop = 1; quota = 1; end
				2: begin pop = 13'h1FFF; quota = 13'h1FFF; end
				3: begin pop = $urandom_range(2, 16); quota = $urandom_range(0, pop); end
				4: begin pop = 0; quota = $urandom_range(0, 13'h1FFF); end
				5: begin pop = $urandom_range(17, 200); quota = pop; end
				6: begin pop = $urandom_range(2, 40); quota = 13'h1FFF; end
				7: begin pop = MAX_POP; quota = $urandom_range(0, 8); end
				8: begin pop = $urandom_range(2, 12); quota = $urandom_range(0, 12); end
				default: begin pop = $urandom_range(1, 64); quota = $urandom_range(0, pop + 2); end
			endcase
			set_regs(CFG_W'(pop), CFG_W'(quota));
			case ($urandom_range(0, 2))
				0: gap_max = 0;
				1: gap_max = 3;
				default: gap_max = 8;
			endcase
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 15;
				2: stall_pct = 40;
				default: stall_pct = 70;
			endcase
			if (k == 0) begin
				gap_max = 0;
				stall_pct = 0;
			end
			fill_random(90);
			if (k == 5) begin
				// sender keeps offering while the receiver holds off
				gap_max = 0;
				hold_asked++;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/swr_pkg.sv
src/swr_ram.sv
src/sample_without_replacement.sv
src/swr_checker.sv
tb/testbench.sv
